@@ hw/rtl/text_console_writer_defines.svh @@
// Assertion macros of the text console writer RTL, used by its top level.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
package tcw_pkg;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CH_W    = 8;
	localparam int ADDR_W  = 11;
	localparam int CELL_W  = 16;
	localparam int CLR_W   = 4;
	localparam int FULL_W  = 13;	// holds row*cols+col for any 5/7-bit cursor
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [CH_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CLR_W-1:0] FG_RESET     = 4'h7;
	localparam logic [CLR_W-1:0] BG_RESET     = 4'h0;
	localparam logic [COL_W-1:0] COLS_RESET   = 7'd80;
	localparam logic [ROW_W-1:0] ROWS_RESET   = 5'd25;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_FG   = 2'd0,
		REG_BG   = 2'd1,
		REG_COLS = 2'd2,
		REG_ROWS = 2'd3
	} reg_idx_t;

	// effective geometry and colors
	typedef struct packed {
		logic [CLR_W-1:0] fg;
		logic [CLR_W-1:0] bg;
		logic [COL_W-1:0] cols;
		logic [ROW_W-1:0] rows;
	} cfg_t;

	typedef struct packed {
		logic item_ld;
		logic rd_item;
		logic cur_upd;
		logic cur_home;
		logic put_we;
		logic sweep_clr;
		logic sweep_go;
		logic sweep_copy;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic scroll_need;
		logic keep_zero;
		logic copy_last;
		logic zero_last;
		logic clr_last;
		logic sweep_pending;
	} sts_t;

endpackage

@@ hw/rtl/tcw_if.sv @@
// Item and result channel interfaces of the text console writer.
interface tcw_item_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [CH_W-1:0]   char_code;
	logic [ADDR_W-1:0] cell_address;

	modport source(output valid, op, char_code, cell_address, input ready);
	modport sink(input valid, op, char_code, cell_address, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic              scrolled;
	logic [CELL_W-1:0] cell_data;

	modport source(output valid, cursor_column, cursor_row, scrolled, cell_data, input ready);
	modport sink(input valid, cursor_column, cursor_row, scrolled, cell_data, output ready);
endinterface

@@ hw/rtl/tcw_cfg.sv @@
// APB register bank: colors and screen geometry, clamped between 1 and the store size.
module tcw_cfg import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = 80,
	parameter int MAX_ROWS    = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [CLR_W-1:0] fg_q;
	logic [CLR_W-1:0] bg_q;
	logic [COL_W-1:0] cols_q;
	logic [ROW_W-1:0] rows_q;
	reg_idx_t         idx;
	logic             wr;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q   <= FG_RESET;
			bg_q   <= BG_RESET;
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (wr) begin
			case (idx)
				REG_FG:   fg_q   <= pwdata[CLR_W-1:0];
				REG_BG:   bg_q   <= pwdata[CLR_W-1:0];
				REG_COLS: cols_q <= pwdata[COL_W-1:0];
				REG_ROWS: rows_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FG:   prdata = PDATA_W'(fg_q);
			REG_BG:   prdata = PDATA_W'(bg_q);
			REG_COLS: prdata = PDATA_W'(cols_q);
			REG_ROWS: prdata = PDATA_W'(rows_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.fg = fg_q;
		cfg.bg = bg_q;
		if (cols_q == '0)
			cfg.cols = COL_W'(1);
		else if ({1'b0, cols_q} > (COL_W+1)'(MAX_COLUMNS))
			cfg.cols = COL_W'(MAX_COLUMNS);
		else
			cfg.cols = cols_q;
		if (rows_q == '0)
			cfg.rows = ROW_W'(1);
		else if ({1'b0, rows_q} > (ROW_W+1)'(MAX_ROWS))
			cfg.rows = ROW_W'(MAX_ROWS);
		else
			cfg.rows = rows_q;
	end

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// Sequencer for put, read, clear, scroll and the reset clearing pass.
module tcw_ctrl import tcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	input  logic       out_ready,
	input  sts_t       sts,
	output logic       in_ready,
	output logic       out_valid,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_PUT,
		S_READ,
		S_CLEAR,
		S_SCR_COPY,
		S_SCR_ZERO,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE) && !sts.sweep_pending;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_INIT: cmd.sweep_go = 1'b1;
			S_IDLE: begin
				cmd.rd_item   = 1'b1;
				cmd.item_ld   = accept;
				cmd.cur_home  = accept && (in_op == OP_CLEAR);
				cmd.sweep_clr = accept && (in_op == OP_CLEAR);
			end
			S_PUT: begin
				cmd.cur_upd   = 1'b1;
				cmd.put_we    = 1'b1;
				cmd.sweep_clr = sts.scroll_need;
				cmd.out_ld    = !sts.scroll_need && slot_free;
			end
			S_READ: cmd.out_ld = slot_free;
			S_CLEAR: cmd.sweep_go = 1'b1;
			S_SCR_COPY: begin
				cmd.sweep_go   = 1'b1;
				cmd.sweep_copy = 1'b1;
			end
			S_SCR_ZERO: cmd.sweep_go = 1'b1;
			S_FIN: cmd.out_ld = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_INIT: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE: if (accept) begin
					case (in_op)
						OP_PUT:   state_q <= S_PUT;
						OP_READ:  state_q <= S_READ;
						OP_CLEAR: state_q <= S_CLEAR;
						default:  state_q <= S_FIN;
					endcase
				end
				S_PUT: begin
					if (sts.scroll_need) begin
						if (sts.keep_zero)
							state_q <= S_SCR_ZERO;
						else
							state_q <= S_SCR_COPY;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					if (slot_free)
						state_q <= S_IDLE;
					else
						state_q <= S_FIN;
				end
				S_CLEAR: if (sts.clr_last) state_q <= S_FIN;
				S_SCR_COPY: if (sts.copy_last) state_q <= S_SCR_ZERO;
				S_SCR_ZERO: if (sts.zero_last) state_q <= S_FIN;
				S_FIN: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/tcw_dp.sv @@
// Datapath: screen store, cursor, sweep pointer and result register.
module tcw_dp import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = 80,
	parameter int MAX_ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic [1:0]        in_op,
	input  logic [CH_W-1:0]   in_char,
	input  logic [ADDR_W-1:0] in_addr,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [COL_W-1:0]  out_col,
	output logic [ROW_W-1:0]  out_row,
	output logic              out_scrolled,
	output logic [CELL_W-1:0] out_data
);

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int PTR_W      = $clog2(CELL_COUNT + 1);

	logic [CELL_W-1:0] mem [CELL_COUNT];

	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [1:0]        op_q;
	logic [CH_W-1:0]   ch_q;
	logic              addr_ok_q;
	logic              scr_q;
	logic [FULL_W-1:0] idx_q;
	logic [PTR_W-1:0]  keep_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              sw_v_s1;
	logic              sw_zero_s1;
	logic [IDX_W-1:0]  sw_dst_s1;
	logic [CELL_W-1:0] rd_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_scr_q;
	logic [CELL_W-1:0] out_data_q;

	logic              nl;
	logic [COL_W:0]    x1;
	logic [ROW_W:0]    y1;
	logic [ROW_W:0]    y2;
	logic              wrap;
	logic              scroll;
	logic [COL_W-1:0]  nx;
	logic [ROW_W-1:0]  ny;
	logic [COL_W-1:0]  cur_col_d;
	logic [ROW_W-1:0]  cur_row_d;
	logic [FULL_W-1:0] row_x;
	logic [FULL_W-1:0] cols_x;
	logic [FULL_W-1:0] rows_m1_x;
	logic [PTR_W-1:0]  cols_p;
	logic [PTR_W-1:0]  ptr_nxt;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CELL_W-1:0] wr_data;

	// cursor advance
	always_comb begin
		nl     = (ch_q == NEWLINE_CODE);
		x1     = nl ? '0 : {1'b0, cur_col_q} + 1'b1;
		y1     = nl ? {1'b0, cur_row_q} + 1'b1 : {1'b0, cur_row_q};
		wrap   = (x1 >= {1'b0, cfg.cols});
		y2     = wrap ? y1 + 1'b1 : y1;
		scroll = (y2 >= {1'b0, cfg.rows});
		nx     = wrap ? '0 : x1[COL_W-1:0];
		ny     = scroll ? cfg.rows - 1'b1 : y2[ROW_W-1:0];
		if (cmd.cur_home) begin
			cur_col_d = '0;
			cur_row_d = '0;
		end else if (cmd.cur_upd) begin
			cur_col_d = nx;
			cur_row_d = ny;
		end else begin
			cur_col_d = cur_col_q;
			cur_row_d = cur_row_q;
		end
	end

	assign row_x     = FULL_W'(cur_row_q);
	assign cols_x    = FULL_W'(cfg.cols);
	assign rows_m1_x = FULL_W'(cfg.rows - 1'b1);
	assign cols_p    = PTR_W'(cfg.cols);
	assign ptr_nxt   = ptr_q + 1'b1;

	assign sts.scroll_need   = scroll;
	assign sts.keep_zero     = (keep_q == '0);
	assign sts.copy_last     = (ptr_nxt == keep_q);
	assign sts.zero_last     = (ptr_nxt == keep_q + cols_p);
	assign sts.clr_last      = (ptr_nxt == PTR_W'(CELL_COUNT));
	assign sts.sweep_pending = sw_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			ptr_q     <= '0;
			sw_v_s1   <= 1'b0;
			scr_q     <= 1'b0;
		end else begin
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			if (cmd.sweep_clr)
				ptr_q <= '0;
			else if (cmd.sweep_go)
				ptr_q <= ptr_nxt;
			sw_v_s1 <= cmd.sweep_go;
			if (cmd.item_ld)
				scr_q <= 1'b0;
			else if (cmd.cur_upd && scroll)
				scr_q <= 1'b1;
		end
	end

	// index of the cursor cell, size of the rows kept by a scroll, sweep stage, item and result registers
	always_ff @(posedge clk) begin
		idx_q      <= row_x * cols_x + FULL_W'(cur_col_q);
		keep_q     <= PTR_W'(cols_x * rows_m1_x);
		sw_zero_s1 <= !cmd.sweep_copy;
		sw_dst_s1  <= ptr_q[IDX_W-1:0];
		if (cmd.item_ld) begin
			op_q      <= in_op;
			ch_q      <= in_char;
			addr_ok_q <= (FULL_W'(in_addr) < FULL_W'(CELL_COUNT));
		end
		if (cmd.out_ld) begin
			out_col_q  <= cur_col_d;
			out_row_q  <= cur_row_d;
			out_scr_q  <= scr_q;
			out_data_q <= ((op_q == OP_READ) && addr_ok_q) ? rd_q : '0;
		end
	end

	// screen store: one read port, one write port
	always_comb begin
		rd_en = cmd.rd_item || (cmd.sweep_go && cmd.sweep_copy);
		if (cmd.sweep_go && cmd.sweep_copy)
			rd_addr = IDX_W'(ptr_q + cols_p);
		else
			rd_addr = IDX_W'(in_addr);
		if (sw_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = sw_dst_s1;
			wr_data = sw_zero_s1 ? '0 : rd_q;
		end else begin
			wr_en   = cmd.put_we && !nl && (idx_q < FULL_W'(CELL_COUNT));
			wr_addr = idx_q[IDX_W-1:0];
			wr_data = {cfg.bg, cfg.fg, ch_q};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign out_scrolled = out_scr_q;
	assign out_data     = out_data_q;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Top level of the text console writer.
//
//  channel   dir  handshake           word
//  item      in   valid/ready         op, char_code, cell_address
//  result    out  valid/ready         cursor_column, cursor_row, scrolled, cell_data
//  apb       in   psel/penable/pready register write/read, 4 regs at 4*i
//
// Put, read and unused op load their result in S_PUT, S_READ or S_FIN.
// Clear: every cell of the store is zeroed, one cell written per cycle.
// Scroll shifts rows up and zeroes the last: one cell moved or zeroed per cycle.
// After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS cells runs before item.ready.
// A held result does not block the next item; it waits only to load its own result.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = 80,
	parameter int MAX_ROWS    = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	tcw_item_if.sink           item,
	tcw_result_if.source       result
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	tcw_cfg #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.out_ready(result.ready),
		.sts      (sts),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.cmd      (cmd)
	);

	tcw_dp #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_op       (item.op),
		.in_char     (item.char_code),
		.in_addr     (item.cell_address),
		.cmd         (cmd),
		.sts         (sts),
		.out_col     (result.cursor_column),
		.out_row     (result.cursor_row),
		.out_scrolled(result.scrolled),
		.out_data    (result.cell_data)
	);

	`TCW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready, !item.ready, "item accepted on back-to-back cycles")
	`TCW_ASSERT_IMPL(a_scroll_no_data, clk, arst_n, result.valid && result.scrolled, result.cell_data == '0, "scrolled result carries cell data")
	`TCW_ASSERT_IMPL(a_put_no_sweep, clk, arst_n, cmd.put_we, !sts.sweep_pending, "cell write collides with sweep write")

endmodule
